/* hw/rtl/bpa_pkg.sv */
// Shared types, codes and constants of the buddy page allocator.
package bpa_pkg;

    // Default sizes of the pool.
    localparam int MAX_PAGES_DEF  = 32768;
    localparam int NUM_RANKS_DEF  = 16;
    localparam int PAGE_BYTES_DEF = 4096;

    // Fixed field widths.
    localparam int ADDR_W       = 48;
    localparam int CMD_W        = 2;
    localparam int RANK_IN_W    = 5;
    localparam int STATUS_W     = 2;
    localparam int VALUE_W      = 16;
    localparam int COUNT_W      = 16;
    localparam int STORE_RANK_W = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 48;
    localparam int TOTAL_IN_W   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_COUNT = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_NOSPC = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        HK_NONE = 2'd0,
        HK_FREE = 2'd1,
        HK_USED = 2'd2
    } head_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POOL_BASE   = 1'b0,
        REG_TOTAL_PAGES = 1'b1
    } cfg_reg_t;

    // One entry of the page store: head kind and stored rank.
    typedef struct packed {
        head_kind_t               kind;
        logic [STORE_RANK_W-1:0]  rank;
    } page_entry_t;

    localparam int ENTRY_W = $bits(page_entry_t);

    typedef enum logic [4:0] {
        CS_CLEAR,
        CS_HEADS,
        CS_IDLE,
        CS_DECODE,
        CS_DIV,
        CS_PCHK,
        CS_PUSE,
        CS_MCHK,
        CS_MUSE,
        CS_MLO,
        CS_ARANK,
        CS_AREAD,
        CS_ACHK,
        CS_ASPLIT,
        CS_ASPLIT_HI,
        CS_AMARK,
        CS_AADDR,
        CS_FINISH
    } ctrl_state_t;

    // Datapath operations, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR_STEP,
        OP_HEAD_STEP,
        OP_LATCH,
        OP_SET_INVAL,
        OP_SET_NOSPC,
        OP_SET_COUNT,
        OP_DIV_STEP,
        OP_READ_P,
        OP_SET_QUERY,
        OP_FREE_MARK,
        OP_READ_BUD,
        OP_MERGE_HI,
        OP_MERGE_LO,
        OP_RANK_INC,
        OP_SCAN_INIT,
        OP_READ_O,
        OP_SCAN_INC,
        OP_SPLIT_LO,
        OP_SPLIT_HI,
        OP_MARK_USED,
        OP_SET_ADDR,
        OP_PUSH
    } dp_op_t;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic rank_bad;
        logic addr_pre_ok;
        logic div_last;
        logic page_ok;
        logic rd_used;
        logic count_zero;
        logic rank_end;
        logic scan_end;
        logic rd_match_i;
        logic split_done;
        logic merge_stop;
        logic bud_match;
        logic clr_last;
        logic heads_last;
        logic rebuild_req;
        logic out_free;
    } dp_status_t;

endpackage

/* hw/rtl/buddy_page_allocator_unit.sv */
// Buddy page allocator: top level joining controller and datapath.
// Reset or a page-count write runs a rebuild (clear sweep, then head pass); no item is taken.
// Query and free divide the offset into a page index (reciprocal multiply, quotient, remainder
// and correction); free then merges level by level. Allocate scans candidate heads of a rank
// through the page-store port, then splits level by level; one item at a time.
// A finished result waits in the output register while the next item is accepted.
module buddy_page_allocator_unit
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int NUM_RANKS  = NUM_RANKS_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  logic [CMD_W-1:0]      command,
    input  logic [RANK_IN_W-1:0]  rank,
    input  logic [ADDR_W-1:0]     address,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [ADDR_W-1:0]     block_address,
    output logic [VALUE_W-1:0]    value
);

    dp_op_t     op;
    dp_status_t st;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .st        (st),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .op        (op)
    );

    bpa_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .NUM_RANKS  (NUM_RANKS),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .st            (st),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .rank          (rank),
        .address       (address),
        .rsp_stall     (rsp_stall),
        .rsp_valid     (rsp_valid),
        .status        (status),
        .block_address (block_address),
        .value         (value)
    );

endmodule

/* hw/rtl/bpa_ram.sv */
// Generic single-port RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read of the same address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bpa_datapath.sv */
// Datapath of the buddy page allocator: registers, page store, counts, divider.
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int NUM_RANKS  = NUM_RANKS_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_op_t                op,
    output dp_status_t            st,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CMD_W-1:0]      command,
    input  logic [RANK_IN_W-1:0]  rank,
    input  logic [ADDR_W-1:0]     address,
    input  logic                  rsp_stall,
    output logic                  rsp_valid,
    output logic [STATUS_W-1:0]   status,
    output logic [ADDR_W-1:0]     block_address,
    output logic [VALUE_W-1:0]    value
);

    localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int TW  = $clog2(MAX_PAGES + 1);
    localparam int RW  = (NUM_RANKS > 1) ? $clog2(NUM_RANKS) : 1;
    localparam int RIW = $clog2(NUM_RANKS + 1);
    localparam int SW  = ((TW > NUM_RANKS) ? TW : NUM_RANKS) + 1;
    localparam int PBW = $clog2(PAGE_BYTES + 1);
    // Offsets that pass the range check fit in DW bits.
    localparam int DW  = PW + PBW;
    localparam int RS  = DW + PBW;
    localparam int RMW = DW + 2;
    localparam longint unsigned LIMIT = longint'(MAX_PAGES) * longint'(PAGE_BYTES);
    localparam longint unsigned RECIP = (64'd1 << RS) / 64'(PAGE_BYTES);
    localparam logic [ADDR_W-1:0] LIMIT_A = ADDR_W'(LIMIT);
    localparam logic [ADDR_W-1:0] PB_A    = ADDR_W'(PAGE_BYTES);
    localparam logic [PBW-1:0]    PB_N    = PBW'(PAGE_BYTES);
    localparam logic [RMW-1:0]    RECIP_M = RMW'(RECIP);

    // Configuration and rebuild state.
    logic [ADDR_W-1:0]  base_reg;
    logic [TW-1:0]      total_reg;
    logic [PW-1:0]      clr_cnt_reg;
    logic [RW-1:0]      hd_rank_reg;
    logic [SW-1:0]      cur_reg;
    logic [COUNT_W-1:0] free_count_reg [NUM_RANKS];
    logic               out_valid_reg;

    // Per-item working registers.
    cmd_t                    cmd_reg;
    logic [RANK_IN_W-1:0]    rank_in_reg;
    logic [ADDR_W-1:0]       rem_reg;
    logic                    pre_ok_reg;
    logic [1:0]              div_step_reg;
    logic [DW+RMW-1:0]       recip_prod_reg;
    logic [PW-1:0]           q_reg;
    logic [PW-1:0]           p_reg;
    logic [STORE_RANK_W-1:0] p_rank_reg;
    logic [RW-1:0]           r_reg;
    logic [RIW-1:0]          i_reg;
    logic [RW-1:0]           want_reg;
    logic [SW-1:0]           o_reg;
    logic [PW+PBW-1:0]       prod_reg;
    status_t                 res_status_reg;
    logic [ADDR_W-1:0]       res_addr_reg;
    logic [VALUE_W-1:0]      res_value_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [ADDR_W-1:0]       out_addr_reg;
    logic [VALUE_W-1:0]      out_value_reg;

    // Page store port.
    logic [PW-1:0]      ram_addr;
    logic               ram_we;
    page_entry_t        wr_entry;
    page_entry_t        rd_entry;
    logic [ENTRY_W-1:0] rd_bits;

    // Derived values.
    logic [SW-1:0]         total_w;
    logic [SW-1:0]         half_w;
    logic [SW-1:0]         bud_w;
    logic                  bud_lo;
    logic [PW-1:0]         lo_pg;
    logic [PW-1:0]         hi_pg;
    logic [STORE_RANK_W-1:0] hi_rank;
    logic [RW-1:0]         r_clamp;
    logic [DW-1:0]         q_by_pb;
    logic [ADDR_W-1:0]     diff_in;
    logic [TW-1:0]         total_in;
    logic                  cfg_total;
    logic                  out_free;
    logic [RW-1:0]         i_idx;

    bpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PAGES)
    ) u_store (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (wr_entry),
        .rdata (rd_bits)
    );

    assign rd_entry = page_entry_t'(rd_bits);

    // Address arithmetic for scan, split and merge.
    always_comb
    begin
        total_w  = SW'(total_reg);
        half_w   = o_reg + (SW'(1) << (i_reg - RIW'(1)));
        bud_w    = SW'(p_reg) ^ (SW'(1) << r_reg);
        bud_lo   = bud_w < SW'(p_reg);
        lo_pg    = bud_lo ? PW'(bud_w) : p_reg;
        hi_pg    = bud_lo ? p_reg : PW'(bud_w);
        hi_rank  = bud_lo ? p_rank_reg : STORE_RANK_W'(r_reg);
        r_clamp  = (8'(rd_entry.rank) > 8'(NUM_RANKS - 1)) ? RW'(NUM_RANKS - 1)
                                                            : RW'(rd_entry.rank);
        q_by_pb  = DW'(q_reg) * DW'(PB_N);
        diff_in  = address - base_reg;
        total_in = (32'(cfg_data[TOTAL_IN_W-1:0]) > 32'(MAX_PAGES))
                   ? TW'(MAX_PAGES) : TW'(cfg_data[TOTAL_IN_W-1:0]);
        cfg_total = cfg_write && (cfg_index == REG_TOTAL_PAGES);
        out_free = !out_valid_reg || !rsp_stall;
        i_idx    = RW'(i_reg);
    end

    // Page store access per operation.
    always_comb
    begin
        ram_addr = p_reg;
        ram_we   = 1'b0;
        wr_entry = '{kind: HK_NONE, rank: '0};
        unique case (op)
            OP_CLR_STEP:
            begin
                ram_addr = clr_cnt_reg;
                ram_we   = 1'b1;
            end
            OP_HEAD_STEP:
            begin
                ram_addr = PW'(cur_reg);
                ram_we   = total_w[hd_rank_reg];
                wr_entry = '{kind: HK_FREE, rank: STORE_RANK_W'(hd_rank_reg)};
            end
            OP_READ_P:
            begin
                ram_addr = q_reg;
            end
            OP_FREE_MARK:
            begin
                ram_addr = p_reg;
                ram_we   = 1'b1;
                wr_entry = '{kind: HK_FREE, rank: rd_entry.rank};
            end
            OP_READ_BUD:
            begin
                ram_addr = PW'(bud_w);
            end
            OP_MERGE_HI:
            begin
                ram_addr = hi_pg;
                ram_we   = 1'b1;
                wr_entry = '{kind: HK_NONE, rank: hi_rank};
            end
            OP_MERGE_LO:
            begin
                ram_addr = lo_pg;
                ram_we   = 1'b1;
                wr_entry = '{kind: HK_FREE, rank: STORE_RANK_W'(r_reg) + STORE_RANK_W'(1)};
            end
            OP_READ_O:
            begin
                ram_addr = PW'(o_reg);
            end
            OP_SPLIT_LO:
            begin
                ram_addr = PW'(o_reg);
                ram_we   = 1'b1;
                wr_entry = '{kind: HK_FREE, rank: STORE_RANK_W'(i_reg - RIW'(1))};
            end
            OP_SPLIT_HI:
            begin
                ram_addr = PW'(half_w);
                ram_we   = half_w < SW'(MAX_PAGES);
                wr_entry = '{kind: HK_FREE, rank: STORE_RANK_W'(i_reg - RIW'(1))};
            end
            OP_MARK_USED:
            begin
                ram_addr = PW'(o_reg);
                ram_we   = 1'b1;
                wr_entry = '{kind: HK_USED, rank: STORE_RANK_W'(want_reg)};
            end
            default:
            begin
                ram_addr = p_reg;
            end
        endcase
    end

    // Control state: configuration, rebuild counters, free counts, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            total_reg     <= TW'(MAX_PAGES);
            clr_cnt_reg   <= '0;
            hd_rank_reg   <= RW'(NUM_RANKS - 1);
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < NUM_RANKS; n++)
            begin
                free_count_reg[n] <= '0;
            end
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_POOL_BASE))
            begin
                base_reg <= cfg_data[ADDR_W-1:0];
            end

            if (op == OP_PUSH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_total)
            begin
                // A page-count write starts a fresh rebuild.
                total_reg   <= total_in;
                clr_cnt_reg <= '0;
                hd_rank_reg <= RW'(NUM_RANKS - 1);
                cur_reg     <= '0;
                for (int n = 0; n < NUM_RANKS; n++)
                begin
                    free_count_reg[n] <= '0;
                end
            end
            else
            begin
                unique case (op)
                    OP_CLR_STEP:
                    begin
                        clr_cnt_reg <= clr_cnt_reg + PW'(1);
                    end
                    OP_HEAD_STEP:
                    begin
                        if (total_w[hd_rank_reg])
                        begin
                            free_count_reg[hd_rank_reg] <= COUNT_W'(1);
                            cur_reg <= cur_reg + (SW'(1) << hd_rank_reg);
                        end
                        hd_rank_reg <= hd_rank_reg - RW'(1);
                    end
                    OP_FREE_MARK:
                    begin
                        free_count_reg[r_clamp] <= free_count_reg[r_clamp] + COUNT_W'(1);
                    end
                    OP_MERGE_LO:
                    begin
                        free_count_reg[r_reg] <= free_count_reg[r_reg] - COUNT_W'(2);
                        free_count_reg[r_reg + RW'(1)] <=
                            free_count_reg[r_reg + RW'(1)] + COUNT_W'(1);
                    end
                    OP_SPLIT_LO:
                    begin
                        free_count_reg[i_idx] <= free_count_reg[i_idx] - COUNT_W'(1);
                        free_count_reg[i_idx - RW'(1)] <=
                            free_count_reg[i_idx - RW'(1)] + COUNT_W'(2);
                    end
                    OP_MARK_USED:
                    begin
                        free_count_reg[want_reg] <= free_count_reg[want_reg] - COUNT_W'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LATCH:
            begin
                cmd_reg        <= cmd_t'(command);
                rank_in_reg    <= rank;
                want_reg       <= RW'(rank - RANK_IN_W'(1));
                i_reg          <= RIW'(rank - RANK_IN_W'(1));
                rem_reg        <= diff_in;
                pre_ok_reg     <= (address >= base_reg) && (diff_in < LIMIT_A);
                div_step_reg   <= 2'd3;
                q_reg          <= '0;
                res_status_reg <= ST_OK;
                res_addr_reg   <= '0;
                res_value_reg  <= '0;
            end
            OP_SET_INVAL:
            begin
                res_status_reg <= ST_INVAL;
            end
            OP_SET_NOSPC:
            begin
                res_status_reg <= ST_NOSPC;
            end
            OP_SET_COUNT:
            begin
                res_value_reg <= free_count_reg[want_reg];
            end
            OP_DIV_STEP:
            begin
                // Page index by reciprocal multiply; the estimate is low by at most one.
                unique case (div_step_reg)
                    2'd3:
                    begin
                        recip_prod_reg <= (DW+RMW)'(rem_reg[DW-1:0]) * (DW+RMW)'(RECIP_M);
                    end
                    2'd2:
                    begin
                        q_reg <= PW'(recip_prod_reg >> RS);
                    end
                    2'd1:
                    begin
                        rem_reg <= rem_reg - ADDR_W'(q_by_pb);
                    end
                    2'd0:
                    begin
                        if (rem_reg >= PB_A)
                        begin
                            rem_reg <= rem_reg - PB_A;
                            q_reg   <= q_reg + PW'(1);
                        end
                    end
                endcase
                div_step_reg <= div_step_reg - 2'd1;
            end
            OP_READ_P:
            begin
                p_reg <= q_reg;
            end
            OP_SET_QUERY:
            begin
                res_value_reg <= VALUE_W'(rd_entry.rank) + VALUE_W'(1);
            end
            OP_FREE_MARK:
            begin
                p_rank_reg <= rd_entry.rank;
                r_reg      <= r_clamp;
            end
            OP_MERGE_LO:
            begin
                p_reg      <= lo_pg;
                p_rank_reg <= STORE_RANK_W'(r_reg) + STORE_RANK_W'(1);
                r_reg      <= r_reg + RW'(1);
            end
            OP_RANK_INC:
            begin
                i_reg <= i_reg + RIW'(1);
            end
            OP_SCAN_INIT:
            begin
                o_reg <= '0;
            end
            OP_SCAN_INC:
            begin
                o_reg <= o_reg + (SW'(1) << i_reg);
            end
            OP_SPLIT_HI:
            begin
                i_reg <= i_reg - RIW'(1);
            end
            OP_MARK_USED:
            begin
                prod_reg <= (PW+PBW)'(PW'(o_reg)) * (PW+PBW)'(PB_N);
            end
            OP_SET_ADDR:
            begin
                res_addr_reg <= base_reg + ADDR_W'(prod_reg);
            end
            OP_PUSH:
            begin
                out_status_reg <= res_status_reg;
                out_addr_reg   <= res_addr_reg;
                out_value_reg  <= res_value_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Status flags for the controller.
    always_comb
    begin
        st.cmd         = cmd_reg;
        st.rank_bad    = (rank_in_reg == '0) || (8'(rank_in_reg) > 8'(NUM_RANKS));
        st.addr_pre_ok = pre_ok_reg;
        st.div_last    = (div_step_reg == 2'd0);
        st.page_ok     = (rem_reg == '0) && (TW'(q_reg) < total_reg);
        st.rd_used     = (rd_entry.kind == HK_USED);
        st.rank_end    = (8'(i_reg) >= 8'(NUM_RANKS));
        st.count_zero  = st.rank_end || (free_count_reg[i_idx] == '0);
        st.scan_end    = (o_reg >= total_w);
        st.rd_match_i  = (rd_entry.kind == HK_FREE) && (8'(rd_entry.rank) == 8'(i_reg));
        st.split_done  = (i_reg == RIW'(want_reg));
        st.merge_stop  = (8'(r_reg) >= 8'(NUM_RANKS - 1)) || (bud_w >= total_w);
        st.bud_match   = (rd_entry.kind == HK_FREE) && (8'(rd_entry.rank) == 8'(r_reg));
        st.clr_last    = (clr_cnt_reg == PW'(MAX_PAGES - 1));
        st.heads_last  = (hd_rank_reg == '0);
        st.rebuild_req = cfg_total;
        st.out_free    = out_free;
    end

    assign rsp_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign block_address = out_addr_reg;
    assign value         = out_value_reg;

    // A result is only loaded into a free output slot.
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_PUSH) |-> out_free)
        else $error("result loaded over an untaken result");

    // The page count never exceeds the store depth.
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(total_reg) <= 32'(MAX_PAGES)))
        else $error("page count above store depth");

    // A split only happens above the lowest rank.
    a_split_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_SPLIT_LO) |-> (i_reg != '0))
        else $error("split at lowest rank");

endmodule

/* hw/rtl/bpa_ctrl.sv */
// Controller state machine of the buddy page allocator.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t st,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    output dp_op_t     op
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath operation.
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        cmd_stall  = (state_reg != CS_IDLE);
        unique case (state_reg)
            CS_CLEAR:
            begin
                op = OP_CLR_STEP;
                if (st.clr_last)
                begin
                    state_next = CS_HEADS;
                end
            end
            CS_HEADS:
            begin
                op = OP_HEAD_STEP;
                if (st.heads_last)
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_IDLE:
            begin
                if (cmd_valid)
                begin
                    op         = OP_LATCH;
                    state_next = CS_DECODE;
                end
            end
            CS_DECODE:
            begin
                unique case (st.cmd)
                    CMD_ALLOC:
                    begin
                        if (st.rank_bad)
                        begin
                            op         = OP_SET_INVAL;
                            state_next = CS_FINISH;
                        end
                        else
                        begin
                            state_next = CS_ARANK;
                        end
                    end
                    CMD_COUNT:
                    begin
                        op         = st.rank_bad ? OP_SET_INVAL : OP_SET_COUNT;
                        state_next = CS_FINISH;
                    end
                    default:
                    begin
                        if (st.addr_pre_ok)
                        begin
                            state_next = CS_DIV;
                        end
                        else
                        begin
                            op         = OP_SET_INVAL;
                            state_next = CS_FINISH;
                        end
                    end
                endcase
            end
            CS_DIV:
            begin
                op = OP_DIV_STEP;
                if (st.div_last)
                begin
                    state_next = CS_PCHK;
                end
            end
            CS_PCHK:
            begin
                if (st.page_ok)
                begin
                    op         = OP_READ_P;
                    state_next = CS_PUSE;
                end
                else
                begin
                    op         = OP_SET_INVAL;
                    state_next = CS_FINISH;
                end
            end
            CS_PUSE:
            begin
                if (st.cmd == CMD_QUERY)
                begin
                    op         = OP_SET_QUERY;
                    state_next = CS_FINISH;
                end
                else if (st.rd_used)
                begin
                    op         = OP_FREE_MARK;
                    state_next = CS_MCHK;
                end
                else
                begin
                    op         = OP_SET_INVAL;
                    state_next = CS_FINISH;
                end
            end
            CS_MCHK:
            begin
                if (st.merge_stop)
                begin
                    state_next = CS_FINISH;
                end
                else
                begin
                    op         = OP_READ_BUD;
                    state_next = CS_MUSE;
                end
            end
            CS_MUSE:
            begin
                if (st.bud_match)
                begin
                    op         = OP_MERGE_HI;
                    state_next = CS_MLO;
                end
                else
                begin
                    state_next = CS_FINISH;
                end
            end
            CS_MLO:
            begin
                op         = OP_MERGE_LO;
                state_next = CS_MCHK;
            end
            CS_ARANK:
            begin
                if (st.rank_end)
                begin
                    op         = OP_SET_NOSPC;
                    state_next = CS_FINISH;
                end
                else if (st.count_zero)
                begin
                    op = OP_RANK_INC;
                end
                else
                begin
                    op         = OP_SCAN_INIT;
                    state_next = CS_AREAD;
                end
            end
            CS_AREAD:
            begin
                if (st.scan_end)
                begin
                    op         = OP_RANK_INC;
                    state_next = CS_ARANK;
                end
                else
                begin
                    op         = OP_READ_O;
                    state_next = CS_ACHK;
                end
            end
            CS_ACHK:
            begin
                if (st.rd_match_i)
                begin
                    state_next = CS_ASPLIT;
                end
                else
                begin
                    op         = OP_SCAN_INC;
                    state_next = CS_AREAD;
                end
            end
            CS_ASPLIT:
            begin
                if (st.split_done)
                begin
                    state_next = CS_AMARK;
                end
                else
                begin
                    op         = OP_SPLIT_LO;
                    state_next = CS_ASPLIT_HI;
                end
            end
            CS_ASPLIT_HI:
            begin
                op         = OP_SPLIT_HI;
                state_next = CS_ASPLIT;
            end
            CS_AMARK:
            begin
                op         = OP_MARK_USED;
                state_next = CS_AADDR;
            end
            CS_AADDR:
            begin
                op         = OP_SET_ADDR;
                state_next = CS_FINISH;
            end
            CS_FINISH:
            begin
                if (st.out_free)
                begin
                    op         = OP_PUSH;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase

        // A page-count write restarts the rebuild.
        if (st.rebuild_req)
        begin
            state_next = CS_CLEAR;
        end
    end

    // The rebuild sweep ends only into the head pass.
    a_clear_to_heads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_CLEAR && st.clr_last && !st.rebuild_req) |=> (state_reg == CS_HEADS))
        else $error("clear sweep did not move to head pass");

    // An accepted item always leaves idle for decode.
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && !st.rebuild_req) |=> (state_reg == CS_DECODE))
        else $error("accepted item not decoded");

    // A result is pushed only from the finish state.
    a_push_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_PUSH) |-> (state_reg == CS_FINISH))
        else $error("result pushed outside finish");

endmodule
